@@ rtl/plt_pkg.sv @@
// shared types, codes and constants for the piecewise linear time table
`timescale 1ns / 1ps

package plt_pkg;

    // fixed field widths of the item and result beats
    localparam int TIME_W     = 32;
    localparam int VAL_W      = 32;
    localparam int SEG_W      = 8;
    localparam int CMD_W      = 2;
    localparam int MAX_COMP   = 3;

    // defaults for the top level parameters
    localparam int DEF_DEPTH  = 256;
    localparam int DEF_COMP   = 3;

    // product of a value step (one bit wider than a value) and a time offset
    localparam int PROD_W     = VAL_W + 1 + TIME_W;
    localparam int DCNT_W     = $clog2(PROD_W);

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic append;
        logic clear;
        logic start_q;
        logic time_rd;
        logic time_cmp;
        logic val_rd;
        logic v0_cap;
        logic v1_cap;
        logic mul;
        logic div;
        logic acc;
        logic load_out;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic count_zero;
        logic scan_hit;
        logic scan_last;
        logic held;
        logic div_last;
        logic comp_last;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/piecewise_linear_time_table.sv @@
// top level of the piecewise linear time table
//
//  channel   direction  handshake                   payload
//  item      in         i_in_valid / o_in_stall     i_command i_sample_time i_value_x/y/z i_enable
//  result    out        o_out_valid / i_out_stall   o_out_x/y/z o_segment_index o_held_last
//
// append and clear are handled in the idle state. a query walks the stored times
// entry by entry through the single time store port, reading and then comparing
// each, then reads two value rows, and per component runs a multiply, a serial
// divide and an add, unless the last value is held; the result beat is then
// loaded once the output register is free.
// reset is synchronous and empties the table. the item side stalls while a
// query is in progress; a finished result waits in the output register.
`timescale 1ns / 1ps

module piecewise_linear_time_table
    import plt_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int COMPONENTS = DEF_COMP
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [TIME_W-1:0] i_sample_time,
    input  logic signed [VAL_W-1:0]  i_value_x,
    input  logic signed [VAL_W-1:0]  i_value_y,
    input  logic signed [VAL_W-1:0]  i_value_z,
    input  logic                     i_enable,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [VAL_W-1:0]  o_out_x,
    output logic signed [VAL_W-1:0]  o_out_y,
    output logic signed [VAL_W-1:0]  o_out_z,
    output logic [SEG_W-1:0]         o_segment_index,
    output logic                     o_held_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencing
    plt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_enable   (i_enable),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // stores and arithmetic
    plt_dp #(
        .DEPTH      (DEPTH),
        .COMPONENTS (COMPONENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_sample_time   (i_sample_time),
        .i_value_x       (i_value_x),
        .i_value_y       (i_value_y),
        .i_value_z       (i_value_z),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_segment_index (o_segment_index),
        .o_held_last     (o_held_last)
    );

`ifndef SYNTH
    // a result is loaded only into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |-> dp_sts.out_free)
        else $error("result loaded over an untaken beat");

    // a started query holds off the item side
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.start_q |=> o_in_stall)
        else $error("item side open during a query");

    // clear empties the table
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.clear |=> dp_sts.count_zero)
        else $error("table not empty after clear");

    // a loaded result shows as valid next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |=> o_out_valid)
        else $error("loaded result not presented");
`endif

endmodule

@@ rtl/plt_ctrl.sv @@
// controller state machine sequencing append, clear and query beats
`timescale 1ns / 1ps

module plt_ctrl
    import plt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_command,
    input  logic             i_enable,
    output logic             o_in_stall,
    input  t_dp_sts          i_sts,
    output t_dp_cmd          o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TRD   = 4'd1;
    localparam logic [3:0] S_TCMP  = 4'd2;
    localparam logic [3:0] S_VRD   = 4'd3;
    localparam logic [3:0] S_V0CAP = 4'd4;
    localparam logic [3:0] S_V1CAP = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_OUTW  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.append = (i_command == CMD_APPEND);
                    o_cmd.clear  = (i_command == CMD_CLEAR);
                    if (i_command == CMD_QUERY && i_enable && !i_sts.count_zero) begin
                        o_cmd.start_q = 1'b1;
                        n_state       = S_TRD;
                    end
                end
            end
            S_TRD: begin
                o_cmd.time_rd = 1'b1;
                n_state       = S_TCMP;
            end
            S_TCMP: begin
                o_cmd.time_cmp = 1'b1;
                n_state = (i_sts.scan_hit || i_sts.scan_last) ? S_VRD : S_TRD;
            end
            S_VRD: begin
                o_cmd.val_rd = 1'b1;
                n_state      = S_V0CAP;
            end
            S_V0CAP: begin
                o_cmd.v0_cap = 1'b1;
                n_state      = i_sts.held ? S_OUTW : S_V1CAP;
            end
            S_V1CAP: begin
                o_cmd.v1_cap = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.comp_last ? S_OUTW : S_MUL;
            end
            S_OUTW: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/plt_dp.sv @@
// datapath: breakpoint stores, segment scan, multiply and serial divide
`timescale 1ns / 1ps

module plt_dp
    import plt_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int COMPONENTS = DEF_COMP
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic signed [TIME_W-1:0] i_sample_time,
    input  logic signed [VAL_W-1:0]  i_value_x,
    input  logic signed [VAL_W-1:0]  i_value_y,
    input  logic signed [VAL_W-1:0]  i_value_z,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic signed [VAL_W-1:0]  o_out_x,
    output logic signed [VAL_W-1:0]  o_out_y,
    output logic signed [VAL_W-1:0]  o_out_z,
    output logic [SEG_W-1:0]         o_segment_index,
    output logic                     o_held_last
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CPW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

    typedef logic [COMPONENTS-1:0][VAL_W-1:0] t_row;

    // stores
    logic [TIME_W-1:0]        r_time_mem [DEPTH];
    t_row                     r_val_mem  [DEPTH];

    // control state
    logic [CW-1:0]            r_count;
    logic                     r_out_valid;

    // payload state
    logic [CW-1:0]            r_idx;
    logic [CW-1:0]            r_hit;
    logic                     r_held;
    logic signed [TIME_W-1:0] r_t;
    logic signed [TIME_W-1:0] r_prev;
    logic signed [TIME_W-1:0] r_tq;
    logic [TIME_W-1:0]        r_dt;
    logic [TIME_W-1:0]        r_span;
    t_row                     r_vrd;
    t_row                     r_v0;
    t_row                     r_v1;
    logic [CPW-1:0]           r_comp;
    logic                     r_neg;
    logic [PROD_W-1:0]        r_prod;
    logic [TIME_W-1:0]        r_rem;
    logic [DCNT_W-1:0]        r_dcnt;
    logic [VAL_W-1:0]         r_res [COMPONENTS];

    logic [VAL_W-1:0]         in_v [MAX_COMP];
    t_row                     new_row;
    logic                     hit_now;
    logic                     last_now;
    logic [AW-1:0]            vaddr;
    logic signed [VAL_W:0]    diff;
    logic [VAL_W:0]           mag;
    logic [TIME_W:0]          rs;
    logic                     ge;
    logic [TIME_W:0]          t_off;
    logic [TIME_W:0]          t_len;
    logic [VAL_W-1:0]         q_lo;

    assign in_v[0] = i_value_x;
    assign in_v[1] = i_value_y;
    assign in_v[2] = i_value_z;

    // row written on an append
    always_comb begin
        for (int c = 0; c < COMPONENTS; c++) begin
            new_row[c] = in_v[c];
        end
    end

    // segment test on the time just read
    assign hit_now  = (r_idx != '0) && (r_prev <= r_t) && (r_tq > r_t);
    assign last_now = !hit_now && ((r_idx + 1'b1) == r_count);
    assign t_off    = {r_t[TIME_W-1], r_t} - {r_prev[TIME_W-1], r_prev};
    assign t_len    = {r_tq[TIME_W-1], r_tq} - {r_prev[TIME_W-1], r_prev};

    // value row address: segment start, then its successor
    assign vaddr = i_cmd.v0_cap ? AW'(r_hit + 1'b1) : r_hit[AW-1:0];

    // value step of the current component
    assign diff = {r_v1[r_comp][VAL_W-1], r_v1[r_comp]}
                - {r_v0[r_comp][VAL_W-1], r_v0[r_comp]};
    assign mag  = diff[VAL_W] ? (~diff + 1'b1) : diff;

    // one restoring divide step
    assign rs   = {r_rem, r_prod[PROD_W-1]};
    assign ge   = (rs >= {1'b0, r_span});
    assign q_lo = r_prod[VAL_W-1:0];

    // status
    always_comb begin
        o_sts            = '0;
        o_sts.count_zero = (r_count == '0);
        o_sts.scan_hit   = hit_now;
        o_sts.scan_last  = last_now;
        o_sts.held       = r_held;
        o_sts.div_last   = (r_dcnt == DCNT_W'(PROD_W - 1));
        o_sts.comp_last  = (r_comp == CPW'(COMPONENTS - 1));
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    // fill count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.append && r_count != CW'(DEPTH)) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // breakpoint stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && r_count != CW'(DEPTH)) begin
            r_time_mem[r_count[AW-1:0]] <= i_sample_time;
            r_val_mem[r_count[AW-1:0]]  <= new_row;
        end
        if (i_cmd.time_rd) begin
            r_tq <= r_time_mem[r_idx[AW-1:0]];
        end
        if (i_cmd.val_rd || i_cmd.v0_cap) begin
            r_vrd <= r_val_mem[vaddr];
        end
    end

    // scan, multiply, divide and accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_q) begin
            r_t   <= i_sample_time;
            r_idx <= '0;
        end
        if (i_cmd.time_cmp) begin
            if (hit_now) begin
                r_hit  <= r_idx - 1'b1;
                r_held <= 1'b0;
                r_dt   <= t_off[TIME_W-1:0];
                r_span <= t_len[TIME_W-1:0];
            end else if (last_now) begin
                r_hit  <= r_count - 1'b1;
                r_held <= 1'b1;
            end else begin
                r_prev <= r_tq;
                r_idx  <= r_idx + 1'b1;
            end
        end
        if (i_cmd.v0_cap) begin
            r_v0 <= r_vrd;
            for (int c = 0; c < COMPONENTS; c++) begin
                r_res[c] <= r_vrd[c];
            end
        end
        if (i_cmd.v1_cap) begin
            r_v1   <= r_vrd;
            r_comp <= '0;
        end
        if (i_cmd.mul) begin
            r_neg  <= diff[VAL_W];
            r_prod <= PROD_W'(mag) * PROD_W'(r_dt);
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div) begin
            r_rem  <= ge ? TIME_W'(rs - {1'b0, r_span}) : rs[TIME_W-1:0];
            r_prod <= {r_prod[PROD_W-2:0], ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.acc) begin
            r_res[r_comp] <= r_neg ? (r_v0[r_comp] - q_lo) : (r_v0[r_comp] + q_lo);
            r_comp        <= r_comp + 1'b1;
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out_x         <= r_res[0];
            o_segment_index <= SEG_W'(r_hit);
            o_held_last     <= r_held;
        end
    end

    generate
        if (COMPONENTS > 1) begin : g_y
            always_ff @(posedge i_clk) begin
                if (i_cmd.load_out) begin
                    o_out_y <= r_res[1];
                end
            end
        end else begin : g_no_y
            assign o_out_y = '0;
        end
        if (COMPONENTS > 2) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_cmd.load_out) begin
                    o_out_z <= r_res[2];
                end
            end
        end else begin : g_no_z
            assign o_out_z = '0;
        end
    endgenerate

    assign o_out_valid = r_out_valid;

endmodule
